// ===== hw/rtl/stdr_pkg.sv =====
// stdr_pkg: shared types and constants of the sorted tuple registry
// depends on nothing; used by stdr_cmp and sorted_tuple_dedup_registry
`default_nettype none

package stdr_pkg;

    // field widths of the stream payloads
    localparam int unsigned TYPE_W      = 3;
    localparam int unsigned VAR_W       = 16;
    localparam int unsigned VALUE_W     = 16;
    localparam int unsigned COND_ID_W   = 10;
    localparam int unsigned IN_TDATA_W  = 40;
    localparam int unsigned OUT_TDATA_W = 16;

    // bit offsets inside the input tdata
    localparam int unsigned IN_TYPE_LSB  = 0;
    localparam int unsigned IN_VAR_LSB   = 3;
    localparam int unsigned IN_VALUE_LSB = 19;

    // condition type codes whose value takes part in the key
    localparam logic [TYPE_W-1:0] COND_EQUAL     = 3'd2;
    localparam logic [TYPE_W-1:0] COND_NOT_EQUAL = 3'd3;

    // outcome of one key compare
    typedef struct packed {
        logic lt;
        logic eq;
    } t_cmp_res;

endpackage

`default_nettype wire

// ===== hw/rtl/stdr_ram.sv =====
// stdr_ram: generic single-write, single-read ram with registered read data
// depends on nothing
`default_nettype none

module stdr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/stdr_cmp.sv =====
// stdr_cmp: shared key comparator, keys packed as {type, var, value}
// depends on stdr_pkg
`default_nettype none

module stdr_cmp #(
    parameter int unsigned WIDTH = 35
) (
    input  wire logic [WIDTH-1:0] i_a,
    input  wire logic [WIDTH-1:0] i_b,
    output stdr_pkg::t_cmp_res    o_res
);

    // type sits in the top bits, so a plain unsigned compare is lexicographic
    always_comb begin
        o_res.lt = (i_a < i_b);
        o_res.eq = (i_a == i_b);
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sorted_tuple_dedup_registry.sv =====
// sorted_tuple_dedup_registry: top level of the de-duplicating condition registry
// depends on stdr_pkg, stdr_ram and stdr_cmp
//
//  channel  | direction | tdata fields, lowest bit up
//  ---------+-----------+------------------------------------------------------
//  s_axis   | in        | cond_type[2:0], var_id[18:3], value_id[34:19], zero
//  m_axis   | out       | cond_id[9:0], was_new[10], status[11], zero
//
// one transaction at a time: an accept state, then per binary-search probe ST_SRCH,
// ST_IDX, ST_ENT (midpoint and index read, entry read, compare), at most
// ceil(log2(MAX_ENTRIES+1)) probes; a miss ends the search in ST_SRCH; an insert then
// passes ST_SHR and ST_SHW for each index slot shifted up (entry_count - position),
// ST_SHR closes the shift, ST_INS writes, ST_OUT hands the result to the output register
// reset clears the entry count and the handshakes; the rams are never cleared
// the input side is ready again once the result is in the output register,
// even while m_axis is stalled
`default_nettype none

module sorted_tuple_dedup_registry #(
    parameter int unsigned MAX_ENTRIES   = 1024,
    parameter int unsigned VAR_ID_BITS   = 16,
    parameter int unsigned VALUE_ID_BITS = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // cond_type, var_id, value_id, zero fill
    input  wire logic                               s_axis_tvalid,
    output      logic                               s_axis_tready,
    input  wire logic [stdr_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // cond_id, was_new, status, zero fill
    output      logic                               m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output      logic [stdr_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    // stored key widths: ids are masked to the parameter widths
    localparam int unsigned VW    = (VAR_ID_BITS < stdr_pkg::VAR_W) ?
                                    VAR_ID_BITS : stdr_pkg::VAR_W;
    localparam int unsigned LW    = (VALUE_ID_BITS < stdr_pkg::VALUE_W) ?
                                    VALUE_ID_BITS : stdr_pkg::VALUE_W;
    localparam int unsigned KEY_W = stdr_pkg::TYPE_W + VW + LW;
    localparam int unsigned IW    = $clog2(MAX_ENTRIES);
    localparam int unsigned CW    = $clog2(MAX_ENTRIES + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SRCH = 3'd1;
    localparam logic [2:0] ST_IDX  = 3'd2;
    localparam logic [2:0] ST_ENT  = 3'd3;
    localparam logic [2:0] ST_SHR  = 3'd4;
    localparam logic [2:0] ST_SHW  = 3'd5;
    localparam logic [2:0] ST_INS  = 3'd6;
    localparam logic [2:0] ST_OUT  = 3'd7;

    logic [2:0]       r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_lo, n_lo;
    logic [CW-1:0]    r_hi, n_hi;
    logic [CW-1:0]    r_mid, n_mid;
    logic [CW-1:0]    r_sh, n_sh;
    logic [KEY_W-1:0] r_key, n_key;
    logic [IW-1:0]    r_res_id, n_res_id;
    logic             r_res_new, n_res_new;
    logic             r_res_full, n_res_full;
    logic             r_mvalid, n_mvalid;
    logic [stdr_pkg::OUT_TDATA_W-1:0] r_mdata, n_mdata;

    // input field extraction and value masking
    logic [stdr_pkg::TYPE_W-1:0] w_type;
    logic [VW-1:0]               w_var;
    logic [LW-1:0]               w_val;

    // ram ports
    logic             w_idx_we;
    logic [IW-1:0]    w_idx_waddr;
    logic [IW-1:0]    w_idx_wdata;
    logic [IW-1:0]    w_idx_raddr;
    logic [IW-1:0]    w_idx_rdata;
    logic             w_ent_we;
    logic [KEY_W-1:0] w_ent_rdata;

    stdr_pkg::t_cmp_res w_cmp;
    logic [31:0]        w_id_ext;

    assign w_type = s_axis_tdata[stdr_pkg::IN_TYPE_LSB +: stdr_pkg::TYPE_W];
    assign w_var  = s_axis_tdata[stdr_pkg::IN_VAR_LSB +: VW];
    assign w_val  = (w_type == stdr_pkg::COND_EQUAL || w_type == stdr_pkg::COND_NOT_EQUAL) ?
                    s_axis_tdata[stdr_pkg::IN_VALUE_LSB +: LW] : '0;

    // sorted index of entry ids
    stdr_ram #(
        .WIDTH (IW),
        .DEPTH (MAX_ENTRIES)
    ) u_idx_ram (
        .i_clk   (i_clk),
        .i_we    (w_idx_we),
        .i_waddr (w_idx_waddr),
        .i_wdata (w_idx_wdata),
        .i_raddr (w_idx_raddr),
        .o_rdata (w_idx_rdata)
    );

    // entry store in order of arrival, read by the id from the index
    stdr_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (w_ent_we),
        .i_waddr (r_count[IW-1:0]),
        .i_wdata (r_key),
        .i_raddr (w_idx_rdata),
        .o_rdata (w_ent_rdata)
    );

    // the one comparator, used once per probe
    stdr_cmp #(
        .WIDTH (KEY_W)
    ) u_cmp (
        .i_a   (r_key),
        .i_b   (w_ent_rdata),
        .o_res (w_cmp)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_mdata;

    // result id is masked to ten bits, zero-extended for small tables
    assign w_id_ext = 32'(r_res_id);

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_mid      = r_mid;
        n_sh       = r_sh;
        n_key      = r_key;
        n_res_id   = r_res_id;
        n_res_new  = r_res_new;
        n_res_full = r_res_full;
        n_mvalid   = r_mvalid;
        n_mdata    = r_mdata;

        w_idx_we    = 1'b0;
        w_idx_waddr = r_sh[IW-1:0];
        w_idx_wdata = w_idx_rdata;
        w_idx_raddr = r_mid[IW-1:0];
        w_ent_we    = 1'b0;

        // output register drains independently of the sequencer
        if (r_mvalid && m_axis_tready) begin
            n_mvalid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_key   = {w_type, w_var, w_val};
                    n_lo    = '0;
                    n_hi    = r_count;
                    n_state = ST_SRCH;
                end
            end
            ST_SRCH: begin
                if (r_lo < r_hi) begin
                    // probe midpoint, index read issued from it in this cycle
                    n_mid       = r_lo + ((r_hi - r_lo) >> 1);
                    w_idx_raddr = n_mid[IW-1:0];
                    n_state     = ST_IDX;
                end else if (r_count >= MAX_CNT) begin
                    // absent and no room: report full, change nothing
                    n_res_id   = '0;
                    n_res_new  = 1'b0;
                    n_res_full = 1'b1;
                    n_state    = ST_OUT;
                end else begin
                    n_sh    = r_count;
                    n_state = ST_SHR;
                end
            end
            ST_IDX: begin
                // index data is back; it addresses the entry read
                n_res_id = w_idx_rdata;
                n_state  = ST_ENT;
            end
            ST_ENT: begin
                if (w_cmp.eq) begin
                    n_res_new  = 1'b0;
                    n_res_full = 1'b0;
                    n_state    = ST_OUT;
                end else begin
                    if (w_cmp.lt) begin
                        n_hi = r_mid;
                    end else begin
                        n_lo = r_mid + CW'(1);
                    end
                    n_state = ST_SRCH;
                end
            end
            ST_SHR: begin
                // shift from the top down to the insert slot
                if (r_sh > r_lo) begin
                    w_idx_raddr = IW'(r_sh - CW'(1));
                    n_state     = ST_SHW;
                end else begin
                    n_state = ST_INS;
                end
            end
            ST_SHW: begin
                w_idx_we    = 1'b1;
                w_idx_waddr = r_sh[IW-1:0];
                w_idx_wdata = w_idx_rdata;
                n_sh        = r_sh - CW'(1);
                n_state     = ST_SHR;
            end
            ST_INS: begin
                w_idx_we    = 1'b1;
                w_idx_waddr = r_lo[IW-1:0];
                w_idx_wdata = r_count[IW-1:0];
                w_ent_we    = 1'b1;
                n_res_id    = r_count[IW-1:0];
                n_res_new   = 1'b1;
                n_res_full  = 1'b0;
                n_count     = r_count + CW'(1);
                n_state     = ST_OUT;
            end
            ST_OUT: begin
                if (!r_mvalid || m_axis_tready) begin
                    n_mvalid = 1'b1;
                    n_mdata  = {4'b0, r_res_full, r_res_new,
                                w_id_ext[stdr_pkg::COND_ID_W-1:0]};
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_mvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_mvalid <= n_mvalid;
        end
    end

    // payload and search registers need no reset
    always_ff @(posedge i_clk) begin
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_mid      <= n_mid;
        r_sh       <= n_sh;
        r_key      <= n_key;
        r_res_id   <= n_res_id;
        r_res_new  <= n_res_new;
        r_res_full <= n_res_full;
        r_mdata    <= n_mdata;
    end

endmodule

`default_nettype wire

// ===== dv/stdr_registry_checker.sv =====
// stdr_registry_checker: predicts and checks the results of the sorted tuple registry
// depends on stdr_pkg; watches both stream channels and reports a mismatch count

module stdr_registry_checker #(
    parameter int unsigned TABLE_DEPTH = 1024
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // condition channel: cond_type, var_id, value_id, zero fill
    input  wire logic                               i_cmd_tvalid,
    input  wire logic                               i_cmd_tready,
    input  wire logic [stdr_pkg::IN_TDATA_W-1:0]    i_cmd_tdata,
    // result channel: cond_id, was_new, status, zero fill
    input  wire logic                               i_rsp_tvalid,
    input  wire logic                               i_rsp_tready,
    input  wire logic [stdr_pkg::OUT_TDATA_W-1:0]   i_rsp_tdata,
    output int unsigned                             o_fail_count,
    output int unsigned                             o_pending,
    output int unsigned                             o_entry_count,
    output int unsigned                             o_found_count,
    output int unsigned                             o_full_count
);

    localparam int unsigned TYPE_W       = stdr_pkg::TYPE_W;
    localparam int unsigned VAR_W        = stdr_pkg::VAR_W;
    localparam int unsigned VALUE_W      = stdr_pkg::VALUE_W;
    localparam int unsigned COND_ID_W    = stdr_pkg::COND_ID_W;
    localparam int unsigned IN_TDATA_W   = stdr_pkg::IN_TDATA_W;
    localparam int unsigned IN_TYPE_LSB  = stdr_pkg::IN_TYPE_LSB;
    localparam int unsigned IN_VAR_LSB   = stdr_pkg::IN_VAR_LSB;
    localparam int unsigned IN_VALUE_LSB = stdr_pkg::IN_VALUE_LSB;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;
    localparam int unsigned RSP_NEW_BIT    = COND_ID_W;
    localparam int unsigned RSP_STATUS_BIT = COND_ID_W + 1;

    // packed so that a plain compare gives type, then variable, then value order
    typedef struct packed {
        logic [TYPE_W-1:0]  ty;
        logic [VAR_W-1:0]   var_id;
        logic [VALUE_W-1:0] value_id;
    } t_cond_key;

    typedef struct packed {
        logic [COND_ID_W-1:0] cond_id;
        logic                 was_new;
        logic                 status;
    } t_cond_reply;

    t_cond_key   key_store [TABLE_DEPTH];
    int unsigned key_order [TABLE_DEPTH];
    int unsigned stored;
    t_cond_reply reply_q [$];
    int unsigned mismatches;
    int unsigned found_cnt;
    int unsigned full_cnt;
    int unsigned rsp_seen;

    // lookup by binary search over the sorted order, insert on a miss
    function automatic t_cond_reply register_tuple(input logic [IN_TDATA_W-1:0] word);
        t_cond_key   key;
        t_cond_reply reply;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        bit          hit;
        key.ty       = word[IN_TYPE_LSB +: TYPE_W];
        key.var_id   = word[IN_VAR_LSB +: VAR_W];
        key.value_id = (key.ty == stdr_pkg::COND_EQUAL || key.ty == stdr_pkg::COND_NOT_EQUAL) ?
                       word[IN_VALUE_LSB +: VALUE_W] : '0;
        lo  = 0;
        hi  = stored;
        mid = 0;
        hit = 1'b0;
        while (lo < hi && !hit) begin
            mid = lo + (hi - lo) / 2;
            if (key == key_store[key_order[mid]]) begin
                hit = 1'b1;
            end else if (key < key_store[key_order[mid]]) begin
                hi = mid;
            end else begin
                lo = mid + 1;
            end
        end
        if (hit) begin
            reply.cond_id = key_order[mid][COND_ID_W-1:0];
            reply.was_new = 1'b0;
            reply.status  = STATUS_OK;
            found_cnt++;
        end else if (stored >= TABLE_DEPTH) begin
            reply.cond_id = '0;
            reply.was_new = 1'b0;
            reply.status  = STATUS_FULL;
            full_cnt++;
        end else begin
            for (int unsigned i = stored; i > lo; i--) begin
                key_order[i] = key_order[i-1];
            end
            key_order[lo]     = stored;
            key_store[stored] = key;
            reply.cond_id     = stored[COND_ID_W-1:0];
            reply.was_new     = 1'b1;
            reply.status      = STATUS_OK;
            stored++;
        end
        return reply;
    endfunction

    always @(posedge i_clk) begin : watch
        t_cond_reply got;
        t_cond_reply want;
        if (!i_rst_n) begin
            stored     = 0;
            found_cnt  = 0;
            full_cnt   = 0;
            mismatches = 0;
            rsp_seen   = 0;
            reply_q.delete();
        end else begin
            if (i_cmd_tvalid && i_cmd_tready) begin
                reply_q.push_back(register_tuple(i_cmd_tdata));
            end
            if (i_rsp_tvalid && i_rsp_tready) begin
                got.cond_id = i_rsp_tdata[COND_ID_W-1:0];
                got.was_new = i_rsp_tdata[RSP_NEW_BIT];
                got.status  = i_rsp_tdata[RSP_STATUS_BIT];
                if (reply_q.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("result %0d: nothing expected, got id %0d new %0b status %0b",
                                 rsp_seen, got.cond_id, got.was_new, got.status);
                    end
                    mismatches++;
                end else begin
                    want = reply_q.pop_front();
                    if (got.cond_id !== want.cond_id || got.was_new !== want.was_new ||
                        got.status !== want.status) begin
                        if (mismatches < 10) begin
                            $write("result %0d: expected id %0d new %0b status %0b, ",
                                   rsp_seen, want.cond_id, want.was_new, want.status);
                            $display("got id %0d new %0b status %0b",
                                     got.cond_id, got.was_new, got.status);
                        end
                        mismatches++;
                    end
                end
                rsp_seen++;
            end
        end
        o_fail_count  <= mismatches;
        o_pending     <= reply_q.size();
        o_entry_count <= stored;
        o_found_count <= found_cnt;
        o_full_count  <= full_cnt;
    end

endmodule

// ===== dv/sorted_tuple_dedup_registry_tb.sv =====
// sorted_tuple_dedup_registry_tb: stimulus and verdict for the sorted tuple registry
// depends on stdr_pkg, the registry rtl and stdr_registry_checker

module sorted_tuple_dedup_registry_tb;

    localparam int unsigned TYPE_W       = stdr_pkg::TYPE_W;
    localparam int unsigned VAR_W        = stdr_pkg::VAR_W;
    localparam int unsigned VALUE_W      = stdr_pkg::VALUE_W;
    localparam int unsigned IN_TDATA_W   = stdr_pkg::IN_TDATA_W;
    localparam int unsigned OUT_TDATA_W  = stdr_pkg::OUT_TDATA_W;
    localparam int unsigned IN_TYPE_LSB  = stdr_pkg::IN_TYPE_LSB;
    localparam int unsigned IN_VAR_LSB   = stdr_pkg::IN_VAR_LSB;
    localparam int unsigned IN_VALUE_LSB = stdr_pkg::IN_VALUE_LSB;

    localparam int unsigned TABLE_DEPTH    = 1024;
    localparam int unsigned RANDOM_ITEMS   = 700;
    localparam int unsigned TAIL_ITEMS     = 60;
    localparam int unsigned LONG_HOLD      = 400;
    // room for the worst lookup plus a full index shift, plus the long hold-off
    localparam int unsigned WATCHDOG_LIMIT = 20000;
    localparam int unsigned DRAIN_CYCLES   = 100;

    // condition type codes not named in the package
    localparam logic [TYPE_W-1:0] COND_EXISTS     = 3'd0;
    localparam logic [TYPE_W-1:0] COND_NOT_EXISTS = 3'd1;
    localparam logic [TYPE_W-1:0] COND_ANY_VALUE  = 3'd4;
    localparam logic [TYPE_W-1:0] COND_RSVD_5     = 3'd5;
    localparam logic [TYPE_W-1:0] COND_RSVD_6     = 3'd6;
    localparam logic [TYPE_W-1:0] COND_RSVD_7     = 3'd7;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    wire logic              s_axis_tready;
    // cond_type, var_id, value_id, zero fill
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    wire logic              m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // cond_id, was_new, status, zero fill
    wire logic [OUT_TDATA_W-1:0] m_axis_tdata;

    int unsigned chk_fail_count;
    int unsigned chk_pending;
    int unsigned chk_entry_count;
    int unsigned chk_found_count;
    int unsigned chk_full_count;

    // hold_req and tail_quiet are shared between the source and sink processes
    bit          hold_req   = 1'b0;   // ask the sink for one long hold-off
    bit          tail_quiet = 1'b0;   // no gaps on either side from here on
    bit          tx_gap_mode = 1'b0;
    int unsigned tx_mode_left = 0;
    int unsigned items_sent = 0;
    int unsigned idle_cycles = 0;
    logic [IN_TDATA_W-1:0] cond_log [$];   // every condition offered so far

    sorted_tuple_dedup_registry #(
        .MAX_ENTRIES   (TABLE_DEPTH),
        .VAR_ID_BITS   (VAR_W),
        .VALUE_ID_BITS (VALUE_W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    stdr_registry_checker #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_tvalid  (s_axis_tvalid),
        .i_cmd_tready  (s_axis_tready),
        .i_cmd_tdata   (s_axis_tdata),
        .i_rsp_tvalid  (m_axis_tvalid),
        .i_rsp_tready  (m_axis_tready),
        .i_rsp_tdata   (m_axis_tdata),
        .o_fail_count  (chk_fail_count),
        .o_pending     (chk_pending),
        .o_entry_count (chk_entry_count),
        .o_found_count (chk_found_count),
        .o_full_count  (chk_full_count)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // offer one condition and hold it until the block takes it
    // entered and left on a rising edge, so each signal sees one assignment per step
    task automatic offer_cond(input logic [TYPE_W-1:0] ty, input logic [VAR_W-1:0] vid,
                              input logic [VALUE_W-1:0] xid);
        logic [IN_TDATA_W-1:0] word;
        word = '0;
        word[IN_TYPE_LSB +: TYPE_W]   = ty;
        word[IN_VAR_LSB +: VAR_W]     = vid;
        word[IN_VALUE_LSB +: VALUE_W] = xid;
        // gappy and gap-free stretches take turns
        if (tx_mode_left == 0) begin
            tx_gap_mode  = ($urandom_range(0, 2) != 0);
            tx_mode_left = $urandom_range(10, 60);
        end
        tx_mode_left--;
        if (tx_gap_mode && !tail_quiet && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        cond_log.push_back(word);
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
    endtask

    // a mix of repeats, near neighbours of known tuples and fresh tuples
    task automatic offer_random_cond();
        logic [IN_TDATA_W-1:0] word;
        logic [TYPE_W-1:0]     ty;
        logic [VAR_W-1:0]      vid;
        logic [VALUE_W-1:0]    xid;
        int unsigned           pick;
        pick = $urandom_range(0, 99);
        vid  = VAR_W'($urandom);
        xid  = VALUE_W'($urandom);
        if (pick < 50 && cond_log.size() != 0) begin
            word = cond_log[$urandom_range(0, cond_log.size() - 1)];
            ty   = word[IN_TYPE_LSB +: TYPE_W];
            vid  = word[IN_VAR_LSB +: VAR_W];
            xid  = word[IN_VALUE_LSB +: VALUE_W];
            if (pick < 35) begin
                // same tuple again; a value that does not count is scrambled
                if (ty != stdr_pkg::COND_EQUAL && ty != stdr_pkg::COND_NOT_EQUAL) begin
                    xid = VALUE_W'($urandom);
                end
            end else begin
                // step one place beside a known tuple in the sort order
                case ($urandom_range(0, 3))
                    0: vid = vid + VAR_W'(1);
                    1: vid = vid - VAR_W'(1);
                    2: xid = xid + VALUE_W'(1);
                    default: xid = xid - VALUE_W'(1);
                endcase
            end
        end else begin
            if ($urandom_range(0, 9) == 0) begin
                ty = TYPE_W'($urandom_range(COND_RSVD_5, COND_RSVD_7));
            end else begin
                ty = TYPE_W'($urandom_range(COND_EXISTS, COND_ANY_VALUE));
            end
            // extremes and a narrow cluster that makes collisions likely
            case ($urandom_range(0, 5))
                0: vid = '0;
                1: vid = '1;
                2: vid = VAR_W'($urandom_range(0, 15));
                default: ;
            endcase
            case ($urandom_range(0, 5))
                0: xid = '0;
                1: xid = '1;
                2: xid = VALUE_W'($urandom_range(0, 7));
                default: ;
            endcase
        end
        offer_cond(ty, vid, xid);
    endtask

    // result sink: random gaps in bursts, one long hold-off on request
    initial begin : result_sink
        int unsigned mode_left;
        bit          gap_mode;
        mode_left = 0;
        gap_mode  = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (mode_left == 0) begin
                gap_mode  = ($urandom_range(0, 3) != 0);
                mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            if (hold_req && !tail_quiet) begin
                // long stall so the block backs up and holds off its input
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (gap_mode && !tail_quiet && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // watchdog: ends the run when no transaction happens on either channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                     idle_cycles, chk_pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin : cond_source
        int unsigned        k;
        logic [VAR_W-1:0]   fill_var;

        // synchronous reset at the start, never asserted again
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, every type code, value ignored or not, repeats
        offer_cond(COND_EXISTS,     16'h0000, 16'h0000);   // first entry, id 0
        offer_cond(COND_EXISTS,     16'h0000, 16'hFFFF);   // same tuple, value ignored
        offer_cond(COND_NOT_EXISTS, 16'hFFFF, 16'h1234);
        offer_cond(stdr_pkg::COND_EQUAL,     16'h0000, 16'h0000);
        offer_cond(stdr_pkg::COND_EQUAL,     16'h0000, 16'hFFFF);   // value counts, so new
        offer_cond(stdr_pkg::COND_EQUAL,     16'hFFFF, 16'hFFFF);
        offer_cond(stdr_pkg::COND_NOT_EQUAL, 16'hFFFF, 16'h0000);
        offer_cond(stdr_pkg::COND_NOT_EQUAL, 16'hFFFF, 16'h0000);   // exact repeat
        offer_cond(COND_ANY_VALUE,  16'h8000, 16'hAAAA);
        offer_cond(COND_ANY_VALUE,  16'h8000, 16'h5555);   // repeat with other value
        offer_cond(COND_RSVD_5,     16'h5555, 16'hFFFF);   // undefined type codes
        offer_cond(COND_RSVD_6,     16'hAAAA, 16'h0001);
        offer_cond(COND_RSVD_7,     16'hFFFF, 16'hFFFF);   // largest possible key
        offer_cond(COND_RSVD_7,     16'hFFFF, 16'h0000);   // same, value forced to zero
        offer_cond(COND_EXISTS,     16'h0000, 16'h0000);
        offer_cond(stdr_pkg::COND_EQUAL,     16'h0000, 16'hFFFF);
        offer_cond(stdr_pkg::COND_EQUAL,     16'h0001, 16'h8000);   // lands mid-index
        offer_cond(COND_NOT_EXISTS, 16'hFFFF, 16'h0000);
        offer_cond(stdr_pkg::COND_NOT_EQUAL, 16'h7FFF, 16'h8001);
        offer_cond(COND_EXISTS,     16'hFFFF, 16'h0000);

        // random: inserts at any place in the index, plenty of repeats
        for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 300) hold_req = 1'b1;
            offer_random_cond();
        end

        // fill the table: mostly keys near the top of the order (cheap appends),
        // now and then one near the bottom that shifts almost the whole index
        hold_req = 1'b1;
        fill_var = 16'hF000;
        k = 0;
        while (chk_entry_count < TABLE_DEPTH && k < 4 * TABLE_DEPTH) begin
            if (k % 50 == 25) begin
                offer_cond(COND_EXISTS, k[VAR_W-1:0], VALUE_W'($urandom));
            end else begin
                fill_var = VAR_W'(fill_var + $urandom_range(1, 3));
                offer_cond(COND_RSVD_7, fill_var, VALUE_W'($urandom));
            end
            k++;
        end

        // full table: repeats still resolve, new tuples are refused; no gaps
        tail_quiet = 1'b1;
        repeat (TAIL_ITEMS) offer_random_cond();
        s_axis_tvalid <= 1'b0;

        // let every result drain, then watch a while for strays
        @(posedge i_clk);
        while (chk_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d conditions registered: %0d stored, %0d found again, %0d refused when full",
                 items_sent, chk_entry_count, chk_found_count, chk_full_count);
        $display("random gaps on both channels, two long result stalls, last %0d without gaps",
                 TAIL_ITEMS);
        if (chk_fail_count == 0 && chk_pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
